@@ src/fqd_pkg.sv @@
// fqd_pkg: shared types and constants for the fifo queue with delete
// no dependencies; imported by fqd_cell and fifo_queue_with_delete

package fqd_pkg;

	localparam int OP_W     = 2;
	localparam int IN_W     = 32;
	localparam int OUT_W    = 32;
	localparam int COUNT_W  = 5;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;

	localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
	localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
	localparam logic [OP_W-1:0] OP_DEL = 2'd2;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FAIL = 1'b1;

	typedef struct packed {
		logic enq_ok;
		logic deq_ok;
		logic del_ok;
	} cell_cmd_t;

endpackage

@@ src/fqd_cell.sv @@
// fqd_cell: one slot of the queue, compares against the request data and
// shifts from its right neighbor on removal; depends on fqd_pkg

module fqd_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int CNT_W      = 5,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  fqd_pkg::cell_cmd_t    cmd,
	input  logic [CNT_W-1:0]      cnt,
	input  logic [DATA_WIDTH-1:0] din,
	input  logic [DATA_WIDTH-1:0] next_data,
	input  logic                  match_in,
	output logic                  match_out,
	output logic [DATA_WIDTH-1:0] data
);
	import fqd_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;
	logic                  occ;
	logic                  hit;

	assign occ       = CNT_W'(IDX) < cnt;
	assign hit       = occ && (data_q == din);
	assign match_out = match_in || hit;
	assign data      = data_q;

	always_ff @(posedge clk) begin
		if (cmd.enq_ok && (cnt == CNT_W'(IDX))) begin
			data_q <= din;
		end else if ((cmd.deq_ok && occ) || (cmd.del_ok && match_out)) begin
			data_q <= next_data;
		end
	end

endmodule

@@ src/fifo_queue_with_delete.sv @@
// fifo_queue_with_delete: bounded fifo of nonzero handles with delete by value
// built from a row of fqd_cell slots; depends on fqd_pkg and fqd_cell
//
//  channel  dir  fields (low bit up)
//  s_axis   in   opcode[1:0], data_in[33:2], zero pad to 40
//  m_axis   out  status[0], data_out[32:1], count[37:33], zero pad to 40
//
// one cycle per request; every cell compares and shifts in the same cycle
// the first-match chain through the row of cells sets the critical path
// a result waits in the output register; a new request is taken in the
// cycle the result leaves, so requests flow back to back under no stall
// reset empties the queue; slot contents are left as they are

module fifo_queue_with_delete #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [fqd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // opcode, data_in
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [fqd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata   // status, data_out, count
);
	import fqd_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [OP_W-1:0]       opcode;
	logic [DATA_WIDTH-1:0] din;
	logic                  din_nz;
	logic                  take;
	cell_cmd_t             cmd;

	logic [CNT_W-1:0]      count_q;
	logic                  out_valid_q;
	logic                  status_q;
	logic [OUT_W-1:0]      data_out_q;
	logic [COUNT_W-1:0]    count_out_q;

	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic [DEPTH:0]        match;
	logic [CNT_W-1:0]      count_d;

	assign opcode = s_axis_tdata[OP_W-1:0];
	assign din    = DATA_WIDTH'(s_axis_tdata[OP_W+IN_W-1:OP_W]);
	assign din_nz = din != '0;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign take          = s_axis_tvalid && s_axis_tready;

	assign match[0]   = 1'b0;
	assign cmd.enq_ok = take && (opcode == OP_ENQ) && din_nz && (count_q != CNT_W'(DEPTH));
	assign cmd.deq_ok = take && (opcode == OP_DEQ) && (count_q != '0);
	assign cmd.del_ok = take && (opcode == OP_DEL) && din_nz && match[DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] nxt;
		if (i == DEPTH - 1) begin : g_last
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cell_data[i+1];
		end
		fqd_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.CNT_W      (CNT_W),
			.IDX        (i)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.cnt       (count_q),
			.din       (din),
			.next_data (nxt),
			.match_in  (match[i]),
			.match_out (match[i+1]),
			.data      (cell_data[i])
		);
	end

	always_comb begin
		count_d = count_q;
		if (cmd.enq_ok) begin
			count_d = count_q + CNT_W'(1);
		end else if (cmd.deq_ok || cmd.del_ok) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q    <= (cmd.enq_ok || cmd.deq_ok || cmd.del_ok) ? ST_OK : ST_FAIL;
			data_out_q  <= cmd.deq_ok ? OUT_W'(cell_data[0]) : '0;
			count_out_q <= COUNT_W'(count_d);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - 1 - OUT_W - COUNT_W){1'b0}},
		count_out_q, data_out_q, status_q};

endmodule
